/* rtl/fbct_pkg.sv */
package fbct_pkg;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [7:0]  AGE_RESET      = 8'd5;

  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_REPORT = 2'd1;
  localparam logic [1:0] KIND_EMPTY  = 2'd2;

  localparam logic [1:0] ST_NEW     = 2'd0;
  localparam logic [1:0] ST_UPDATED = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  localparam logic [47:0] MAX48 = {48{1'b1}};
  localparam logic [31:0] MAX32 = {32{1'b1}};

  // one table entry: key and counters
  typedef struct packed {
    logic        is_tcp;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [47:0] interval_bytes;
    logic [47:0] total_bytes;
    logic [31:0] packets;
    logic [7:0]  age;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

/* rtl/flow_byte_counter_table.sv */
// Flow byte counter table. Each request is a parsed packet header (cmd 0) or an
// interval tick (cmd 1). Flow entries live in one single-port-read RAM of
// FLOW_SLOTS entries with a valid bit per slot in flip-flops. A packet walks
// the table one slot per cycle comparing keys against the registered RAM read;
// an ignored packet gets its status result straight from idle, without a walk.
// A tick walks every slot, reporting each valid flow as one result and
// writing it back aged, or dropping it if its age is zero; output stalls can
// hold the walk. One request is handled at a time; results leave through a
// register.
module flow_byte_counter_table #(
  parameter int FLOW_SLOTS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic [15:0] ether_type,
  input  logic        more_fragments,
  input  logic [7:0]  ip_protocol,
  input  logic [31:0] src_addr,
  input  logic [31:0] dst_addr,
  input  logic [15:0] src_port,
  input  logic [15:0] dst_port,
  input  logic [15:0] frame_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [1:0]  status,
  output logic [5:0]  slot,
  output logic        is_tcp,
  output logic [31:0] flow_src_addr,
  output logic [31:0] flow_dst_addr,
  output logic [15:0] flow_src_port,
  output logic [15:0] flow_dst_port,
  output logic [47:0] interval_bytes,
  output logic [47:0] total_bytes,
  output logic [31:0] packet_count,
  output logic        last
);
  import fbct_pkg::*;

  localparam int AW = $clog2(FLOW_SLOTS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_WRITE = 3'd2;
  localparam logic [2:0] S_TICK  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;
  localparam logic [2:0] S_TEND  = 3'd5;

  logic [2:0]  state;
  logic [7:0]  age_reload;
  logic [FLOW_SLOTS-1:0] valid;

  // latched request
  logic        r_tcp;
  logic [31:0] r_saddr, r_daddr;
  logic [15:0] r_sport, r_dport, r_len;

  // walk control
  logic [AW:0] idx;        // address being read
  logic        rd_pend;    // rdata holds entry of rd_idx
  logic [AW-1:0] rd_idx;
  logic        hit, have_free;
  logic [AW-1:0] hit_idx, free_idx;
  logic        rep_hold;   // tick: report waiting for next to mark last

  // RAM
  logic          we;
  logic [AW-1:0] waddr, raddr;
  entry_t        wdata, rdata, hit_e;

  fbct_ram #(.WIDTH(ENTRY_W), .DEPTH(FLOW_SLOTS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  // output register
  logic        out_free;
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && out_free;

  logic pkt_ok;
  assign pkt_ok = (ether_type == ETHERTYPE_IPV4) && !more_fragments &&
                  (ip_protocol == PROTO_TCP || ip_protocol == PROTO_UDP);

  // a result is loaded into the output register this cycle
  logic out_load;
  always_comb begin
    case (state)
      S_IDLE:  out_load = in_valid && in_ready && !cmd && !pkt_ok;
      S_WRITE: out_load = out_free;
      S_TICK:  out_load = rep_hold && rd_pend && valid[rd_idx] && out_free;
      S_TEND:  out_load = out_free;
      default: out_load = 1'b0;
    endcase
  end

  logic key_eq;
  assign key_eq = rdata.is_tcp == r_tcp && rdata.src_addr == r_saddr &&
                  rdata.dst_addr == r_daddr && rdata.src_port == r_sport &&
                  rdata.dst_port == r_dport;

  // keep rereading the pending slot while the held report waits to flush
  assign raddr = (state == S_TICK && rep_hold && rd_pend && valid[rd_idx]) ?
                 rd_idx : idx[AW-1:0];

  // held report from tick walk
  entry_t      rep_e;
  logic [AW-1:0] rep_idx;

  // saturating adds
  logic [48:0] ib_sum, tb_sum;
  logic [32:0] pk_sum;
  assign ib_sum = {1'b0, hit_e.interval_bytes} + {33'd0, r_len};
  assign tb_sum = {1'b0, hit_e.total_bytes} + {33'd0, r_len};
  assign pk_sum = {1'b0, hit_e.packets} + 33'd1;

  entry_t upd_e;
  always_comb begin
    upd_e = hit_e;
    if (hit) begin
      upd_e.interval_bytes = ib_sum[48] ? MAX48 : ib_sum[47:0];
      upd_e.total_bytes    = tb_sum[48] ? MAX48 : tb_sum[47:0];
      upd_e.packets        = pk_sum[32] ? MAX32 : pk_sum[31:0];
    end else begin
      upd_e.is_tcp = r_tcp;
      upd_e.src_addr = r_saddr;
      upd_e.dst_addr = r_daddr;
      upd_e.src_port = r_sport;
      upd_e.dst_port = r_dport;
      upd_e.interval_bytes = {32'd0, r_len};
      upd_e.total_bytes    = {32'd0, r_len};
      upd_e.packets        = 32'd1;
    end
    upd_e.age = age_reload;
  end

  // aged copy of the entry just read in a tick walk
  entry_t aged_e;
  always_comb begin
    aged_e = rdata;
    aged_e.interval_bytes = '0;
    aged_e.age = rdata.age - 8'd1;
  end

  always_comb begin
    we = 1'b0;
    waddr = rd_idx;
    wdata = aged_e;
    if (state == S_WRITE) begin
      // nothing is written when the table is full
      we = hit || have_free;
      waddr = hit ? hit_idx : free_idx;
      wdata = upd_e;
    end else if (state == S_TICK && rd_pend && valid[rd_idx] && !rep_hold) begin
      we = rdata.age != 8'd0;
    end
  end

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      age_reload <= AGE_RESET;
    end else if (cfg_we) begin
      age_reload <= cfg_wdata;
    end
  end

  // main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= '0;
      out_valid <= 1'b0;
      idx <= '0;
      rd_pend <= 1'b0;
      hit <= 1'b0;
      have_free <= 1'b0;
      rep_hold <= 1'b0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          idx <= '0;
          rd_pend <= 1'b0;
          hit <= 1'b0;
          have_free <= 1'b0;
          rep_hold <= 1'b0;
          if (in_valid && in_ready) begin
            r_tcp   <= ip_protocol == PROTO_TCP;
            r_saddr <= src_addr;
            r_daddr <= dst_addr;
            r_sport <= src_port;
            r_dport <= dst_port;
            r_len   <= frame_length;
            if (cmd) begin
              state <= S_TICK;
            end else if (pkt_ok) begin
              state <= S_SCAN;
            end else begin
              kind <= KIND_STATUS;
              status <= ST_IGNORED;
              slot <= '0;
              is_tcp <= 1'b0;
              flow_src_addr <= '0;
              flow_dst_addr <= '0;
              flow_src_port <= '0;
              flow_dst_port <= '0;
              interval_bytes <= '0;
              total_bytes <= '0;
              packet_count <= '0;
              last <= 1'b1;
            end
          end
        end
        S_SCAN: begin
          // read idx, compare previous read
          if (rd_pend) begin
            if (valid[rd_idx]) begin
              if (!hit && key_eq) begin
                hit <= 1'b1;
                hit_idx <= rd_idx;
                hit_e <= rdata;
              end
            end else if (!have_free) begin
              have_free <= 1'b1;
              free_idx <= rd_idx;
            end
          end
          rd_idx <= idx[AW-1:0];
          if (idx == (AW+1)'(FLOW_SLOTS)) begin
            rd_pend <= 1'b0;
            state <= S_WRITE;
          end else begin
            rd_pend <= 1'b1;
            idx <= idx + 1'b1;
          end
        end
        S_WRITE: begin
          if (out_free) begin
            kind <= KIND_STATUS;
            last <= 1'b1;
            is_tcp <= r_tcp;
            flow_src_addr <= r_saddr;
            flow_dst_addr <= r_daddr;
            flow_src_port <= r_sport;
            flow_dst_port <= r_dport;
            if (hit || have_free) begin
              status <= hit ? ST_UPDATED : ST_NEW;
              slot <= 6'(hit ? hit_idx : free_idx);
              interval_bytes <= upd_e.interval_bytes;
              total_bytes <= upd_e.total_bytes;
              packet_count <= upd_e.packets;
              if (!hit) valid[free_idx] <= 1'b1;
            end else begin
              status <= ST_FULL;
              slot <= '0;
              interval_bytes <= '0;
              total_bytes <= '0;
              packet_count <= '0;
            end
            state <= S_IDLE;
          end
        end
        S_TICK: begin
          // hold a report until the next one is seen, to know which is last
          if (rd_pend && valid[rd_idx] && !rep_hold) begin
            rep_hold <= 1'b1;
            rep_e <= rdata;
            rep_idx <= rd_idx;
            if (rdata.age == 8'd0) valid[rd_idx] <= 1'b0;
            rd_pend <= 1'b0;
          end else if (rep_hold && rd_pend && valid[rd_idx]) begin
            // another report pending: flush the held one first
            if (out_free) begin
              kind <= KIND_REPORT;
              status <= ST_NEW;
              slot <= 6'(rep_idx);
              is_tcp <= rep_e.is_tcp;
              flow_src_addr <= rep_e.src_addr;
              flow_dst_addr <= rep_e.dst_addr;
              flow_src_port <= rep_e.src_port;
              flow_dst_port <= rep_e.dst_port;
              interval_bytes <= rep_e.interval_bytes;
              total_bytes <= rep_e.total_bytes;
              packet_count <= rep_e.packets;
              last <= 1'b0;
              rep_hold <= 1'b0;
            end
          end else if (idx == (AW+1)'(FLOW_SLOTS)) begin
            rd_pend <= 1'b0;
            state <= S_TEND;
          end else begin
            rd_idx <= idx[AW-1:0];
            rd_pend <= 1'b1;
            idx <= idx + 1'b1;
          end
        end
        S_TEND: begin
          if (out_free) begin
            status <= ST_NEW;
            last <= 1'b1;
            if (rep_hold) begin
              kind <= KIND_REPORT;
              slot <= 6'(rep_idx);
              is_tcp <= rep_e.is_tcp;
              flow_src_addr <= rep_e.src_addr;
              flow_dst_addr <= rep_e.dst_addr;
              flow_src_port <= rep_e.src_port;
              flow_dst_port <= rep_e.dst_port;
              interval_bytes <= rep_e.interval_bytes;
              total_bytes <= rep_e.total_bytes;
              packet_count <= rep_e.packets;
            end else begin
              kind <= KIND_EMPTY;
              slot <= '0;
              is_tcp <= 1'b0;
              flow_src_addr <= '0;
              flow_dst_addr <= '0;
              flow_src_port <= '0;
              flow_dst_port <= '0;
              interval_bytes <= '0;
              total_bytes <= '0;
              packet_count <= '0;
            end
            state <= S_IDLE;
          end
        end
        S_EMIT: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/fbct_ram.sv */
module fbct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/fbct_checker.sv */
module fbct_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] kind,
  input logic [1:0] status,
  input logic [5:0] slot,
  input logic       last
);
  import fbct_pkg::*;

  // output request holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(last))
    else $error("output changed while stalled");

  // packet status is always a single, final result
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_STATUS |-> last)
    else $error("packet status without last");

  // empty tick reports only its own marker
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_EMPTY |-> last && slot == 6'd0)
    else $error("empty tick malformed");

  // flow reports carry status zero
  a_report_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_REPORT |-> status == ST_NEW)
    else $error("report with nonzero status");

  // a new request is taken only when the output register can be loaded
  a_in_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid || out_ready)
    else $error("input ready with output blocked");

endmodule

bind flow_byte_counter_table fbct_checker u_fbct_checker (
  .clk(clk), .rst(rst), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .kind(kind),
  .status(status), .slot(slot), .last(last)
);

/* tb/sv/testbench.sv */
module testbench;
  import fbct_pkg::*;

  localparam int SLOTS = 64;

  typedef struct {
    logic        cmd;
    logic [15:0] ether_type;
    logic        more_fragments;
    logic [7:0]  ip_protocol;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [15:0] frame_length;
  } request_t;

  typedef struct {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [5:0]  slot;
    logic        is_tcp;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [47:0] interval_bytes;
    logic [47:0] total_bytes;
    logic [31:0] packet_count;
    logic        last;
  } flow_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [7:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic cmd = 1'b0;
  logic [15:0] ether_type = '0;
  logic more_fragments = 1'b0;
  logic [7:0] ip_protocol = '0;
  logic [31:0] src_addr = '0;
  logic [31:0] dst_addr = '0;
  logic [15:0] src_port = '0;
  logic [15:0] dst_port = '0;
  logic [15:0] frame_length = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] kind;
  logic [1:0] status;
  logic [5:0] slot;
  logic is_tcp;
  logic [31:0] flow_src_addr;
  logic [31:0] flow_dst_addr;
  logic [15:0] flow_src_port;
  logic [15:0] flow_dst_port;
  logic [47:0] interval_bytes;
  logic [47:0] total_bytes;
  logic [31:0] packet_count;
  logic last;

  flow_byte_counter_table dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .ether_type(ether_type), .more_fragments(more_fragments),
    .ip_protocol(ip_protocol), .src_addr(src_addr), .dst_addr(dst_addr),
    .src_port(src_port), .dst_port(dst_port), .frame_length(frame_length),
    .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .status(status), .slot(slot), .is_tcp(is_tcp),
    .flow_src_addr(flow_src_addr), .flow_dst_addr(flow_dst_addr),
    .flow_src_port(flow_src_port), .flow_dst_port(flow_dst_port),
    .interval_bytes(interval_bytes), .total_bytes(total_bytes),
    .packet_count(packet_count), .last(last)
  );

  // clock, period 20
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // shadow flow table
  bit          tbl_valid[SLOTS];
  logic        tbl_tcp[SLOTS];
  logic [31:0] tbl_saddr[SLOTS];
  logic [31:0] tbl_daddr[SLOTS];
  logic [15:0] tbl_sport[SLOTS];
  logic [15:0] tbl_dport[SLOTS];
  logic [47:0] tbl_ibytes[SLOTS];
  logic [47:0] tbl_tbytes[SLOTS];
  logic [31:0] tbl_pkts[SLOTS];
  logic [7:0]  tbl_age[SLOTS];
  logic [7:0]  age_reload = AGE_RESET;

  flow_result_t expected_results[$];
  int errors = 0;

  // random key pool for well-formed traffic
  request_t flow_pool[96];
  int pool_size = 8;
  int burst_left = 0;

  function automatic logic [47:0] add_sat48(logic [47:0] a, logic [15:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {33'd0, b};
    return s[48] ? MAX48 : s[47:0];
  endfunction

  function automatic flow_result_t slot_result(int s, logic [1:0] k, logic [1:0] st);
    flow_result_t r;
    r.kind = k;
    r.status = st;
    r.slot = s[5:0];
    r.is_tcp = tbl_tcp[s];
    r.src_addr = tbl_saddr[s];
    r.dst_addr = tbl_daddr[s];
    r.src_port = tbl_sport[s];
    r.dst_port = tbl_dport[s];
    r.interval_bytes = tbl_ibytes[s];
    r.total_bytes = tbl_tbytes[s];
    r.packet_count = tbl_pkts[s];
    r.last = 1'b0;
    return r;
  endfunction

  // tick: report every valid flow, then clear interval bytes and age
  task automatic predict_tick();
    flow_result_t r;
    int n;
    n = 0;
    for (int s = 0; s < SLOTS; s++) begin
      if (tbl_valid[s]) begin
        expected_results.push_back(slot_result(s, KIND_REPORT, ST_NEW));
        n++;
        tbl_ibytes[s] = '0;
        if (tbl_age[s] == 0) tbl_valid[s] = 1'b0;
        else tbl_age[s]--;
      end
    end
    if (n == 0) begin
      r = '{default: '0};
      r.kind = KIND_EMPTY;
      r.last = 1'b1;
      expected_results.push_back(r);
    end else begin
      expected_results[$].last = 1'b1;
    end
  endtask

  // packet: match, claim a free slot, or drop
  task automatic predict_packet(request_t q);
    flow_result_t r;
    logic tcp;
    int hit;
    int free_slot;
    r = '{default: '0};
    r.last = 1'b1;
    if (q.ether_type != ETHERTYPE_IPV4 || q.more_fragments ||
        (q.ip_protocol != PROTO_TCP && q.ip_protocol != PROTO_UDP)) begin
      r.status = ST_IGNORED;
      expected_results.push_back(r);
      return;
    end
    tcp = (q.ip_protocol == PROTO_TCP);
    hit = -1;
    free_slot = -1;
    for (int s = 0; s < SLOTS; s++) begin
      if (tbl_valid[s]) begin
        if (hit < 0 && tbl_tcp[s] == tcp && tbl_saddr[s] == q.src_addr &&
            tbl_daddr[s] == q.dst_addr && tbl_sport[s] == q.src_port &&
            tbl_dport[s] == q.dst_port)
          hit = s;
      end else if (free_slot < 0) begin
        free_slot = s;
      end
    end
    if (hit >= 0) begin
      tbl_ibytes[hit] = add_sat48(tbl_ibytes[hit], q.frame_length);
      tbl_tbytes[hit] = add_sat48(tbl_tbytes[hit], q.frame_length);
      if (tbl_pkts[hit] != MAX32) tbl_pkts[hit]++;
      tbl_age[hit] = age_reload;
      r = slot_result(hit, KIND_STATUS, ST_UPDATED);
    end else if (free_slot >= 0) begin
      tbl_valid[free_slot] = 1'b1;
      tbl_tcp[free_slot] = tcp;
      tbl_saddr[free_slot] = q.src_addr;
      tbl_daddr[free_slot] = q.dst_addr;
      tbl_sport[free_slot] = q.src_port;
      tbl_dport[free_slot] = q.dst_port;
      tbl_ibytes[free_slot] = {32'd0, q.frame_length};
      tbl_tbytes[free_slot] = {32'd0, q.frame_length};
      tbl_pkts[free_slot] = 32'd1;
      tbl_age[free_slot] = age_reload;
      r = slot_result(free_slot, KIND_STATUS, ST_NEW);
    end else begin
      r.status = ST_FULL;
      r.is_tcp = tcp;
      r.src_addr = q.src_addr;
      r.dst_addr = q.dst_addr;
      r.src_port = q.src_port;
      r.dst_port = q.dst_port;
    end
    r.last = 1'b1;
    expected_results.push_back(r);
  endtask

  // offer one request, hold until accepted, then maybe pause
  task automatic send_request(request_t q);
    @(negedge clk);
    cmd = q.cmd;
    ether_type = q.ether_type;
    more_fragments = q.more_fragments;
    ip_protocol = q.ip_protocol;
    src_addr = q.src_addr;
    dst_addr = q.dst_addr;
    src_port = q.src_port;
    dst_port = q.dst_port;
    frame_length = q.frame_length;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    if (q.cmd) predict_tick();
    else predict_packet(q);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(5, 40) : $urandom_range(0, 4))
        @(negedge clk);
      burst_left = $urandom_range(0, 12);
    end
  endtask

  // drain the block, then write age_reload
  task automatic write_age_reload(logic [7:0] v);
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (2 * SLOTS + 20) @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    age_reload = v;
  endtask

  function automatic request_t make_packet(logic tcp, logic [31:0] sa, logic [31:0] da,
                                           logic [15:0] sp, logic [15:0] dp,
                                           logic [15:0] len);
    request_t q;
    q.cmd = 1'b0;
    q.ether_type = ETHERTYPE_IPV4;
    q.more_fragments = 1'b0;
    q.ip_protocol = tcp ? PROTO_TCP : PROTO_UDP;
    q.src_addr = sa;
    q.dst_addr = da;
    q.src_port = sp;
    q.dst_port = dp;
    q.frame_length = len;
    return q;
  endfunction

  function automatic request_t make_tick();
    request_t q;
    q = '{default: '0};
    q.cmd = 1'b1;
    return q;
  endfunction

  function automatic request_t make_noise();
    request_t q;
    q.cmd = 1'b0;
    q.ether_type = $urandom_range(0, 1) ? ETHERTYPE_IPV4 : 16'($urandom);
    q.more_fragments = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 2))
      0: q.ip_protocol = PROTO_TCP;
      1: q.ip_protocol = PROTO_UDP;
      default: q.ip_protocol = 8'($urandom);
    endcase
    q.src_addr = $urandom;
    q.dst_addr = $urandom;
    q.src_port = 16'($urandom);
    q.dst_port = 16'($urandom);
    q.frame_length = 16'($urandom);
    return q;
  endfunction

  // header checks, extremes, update and aging on the reset reload
  task automatic test_basic_flows();
    request_t q;
    send_request(make_tick());
    q = make_packet(1'b1, '1, '1, '1, '1, '1);
    q.ether_type = 16'hFFFF;
    send_request(q);
    q.ether_type = ETHERTYPE_IPV4;
    q.more_fragments = 1'b1;
    send_request(q);
    q.more_fragments = 1'b0;
    q.ip_protocol = 8'hFF;
    send_request(q);
    q.ip_protocol = 8'h00;
    send_request(q);
    send_request(make_packet(1'b1, '1, '1, '1, '1, '1));
    send_request(make_packet(1'b0, '0, '0, '0, '0, '0));
    send_request(make_packet(1'b1, '1, '1, '1, '1, 16'd1));
    send_request(make_packet(1'b0, '1, '1, '1, '1, 16'd100));
    send_request(make_packet(1'b0, '0, '0, '0, '0, '1));
    send_request(make_tick());
    send_request(make_packet(1'b1, '1, '1, '1, '1, 16'd7));
    repeat (6) send_request(make_tick());
  endtask

  // a zero reload removes the flow at the next tick
  task automatic test_zero_reload();
    write_age_reload(8'd0);
    send_request(make_packet(1'b0, 32'h0A000001, 32'h0A000002, 16'd53, 16'd5353, 16'd64));
    send_request(make_tick());
    send_request(make_tick());
  endtask

  // fill every slot, then overflow with both protocols
  task automatic test_full_table();
    write_age_reload(8'd255);
    for (int i = 0; i < SLOTS; i++)
      send_request(make_packet(i[0], $urandom, 32'(i), 16'($urandom), 16'(i),
                               16'($urandom)));
    send_request(make_packet(1'b1, 32'h12345678, 32'h9ABCDEF0, 16'h8000, 16'h0001, 16'd9));
    send_request(make_packet(1'b0, 32'h87654321, 32'h0FEDCBA9, 16'h0001, 16'h8000, 16'd9));
    send_request(make_tick());
    write_age_reload(8'd0);
    send_request(make_packet(1'b1, 32'h1, 32'h2, 16'h3, 16'h4, 16'd5));
    send_request(make_tick());
    send_request(make_tick());
  endtask

  // random traffic drawn mostly from a pool of flows
  task automatic test_random_traffic(int count, logic [7:0] reload);
    request_t q;
    int pick;
    write_age_reload(reload);
    pool_size = $urandom_range(4, 96);
    for (int i = 0; i < pool_size; i++)
      flow_pool[i] = make_packet(1'($urandom_range(0, 1)), $urandom, $urandom,
                                 16'($urandom), 16'($urandom), '0);
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        q = make_tick();
      end else if (pick < 85) begin
        q = flow_pool[$urandom_range(0, pool_size - 1)];
        q.frame_length = $urandom_range(0, 9) == 0 ? '1 : 16'($urandom_range(0, 1600));
      end else begin
        q = make_noise();
      end
      send_request(q);
    end
  endtask

  // receiver stall pattern: switches between free flow, light and heavy stalls
  int stall_mode = 0;
  int stall_timer = 0;
  always @(negedge clk) begin
    if (stall_timer == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_timer <= $urandom_range(20, 200);
    end else begin
      stall_timer <= stall_timer - 1;
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      default: out_ready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    flow_result_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result kind=%0d slot=%0d", kind, slot);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (kind !== e.kind) begin
          $error("kind exp %0d got %0d", e.kind, kind); errors++;
        end
        if (status !== e.status) begin
          $error("status exp %0d got %0d", e.status, status); errors++;
        end
        if (slot !== e.slot) begin
          $error("slot exp %0d got %0d", e.slot, slot); errors++;
        end
        if (is_tcp !== e.is_tcp) begin
          $error("is_tcp exp %0d got %0d", e.is_tcp, is_tcp); errors++;
        end
        if (flow_src_addr !== e.src_addr) begin
          $error("flow_src_addr exp %h got %h", e.src_addr, flow_src_addr); errors++;
        end
        if (flow_dst_addr !== e.dst_addr) begin
          $error("flow_dst_addr exp %h got %h", e.dst_addr, flow_dst_addr); errors++;
        end
        if (flow_src_port !== e.src_port) begin
          $error("flow_src_port exp %h got %h", e.src_port, flow_src_port); errors++;
        end
        if (flow_dst_port !== e.dst_port) begin
          $error("flow_dst_port exp %h got %h", e.dst_port, flow_dst_port); errors++;
        end
        if (interval_bytes !== e.interval_bytes) begin
          $error("interval_bytes exp %0d got %0d", e.interval_bytes, interval_bytes);
          errors++;
        end
        if (total_bytes !== e.total_bytes) begin
          $error("total_bytes exp %0d got %0d", e.total_bytes, total_bytes); errors++;
        end
        if (packet_count !== e.packet_count) begin
          $error("packet_count exp %0d got %0d", e.packet_count, packet_count); errors++;
        end
        if (last !== e.last) begin
          $error("last exp %0d got %0d", e.last, last); errors++;
        end
      end
    end
  end

  // watchdog
  initial begin
    #60_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_basic_flows();
    test_zero_reload();
    test_full_table();
    test_random_traffic(85, 8'd1);
    test_random_traffic(85, 8'd255);
    test_random_traffic(85, 8'd5);
    test_random_traffic(84, 8'd2);
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (2 * SLOTS + 50) @(negedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
